// File: hw/rtl/epg_pkg.sv
package epg_pkg;

    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam logic [12:0] ANGLE_FULL    = 13'd3600;
    localparam logic [11:0] ANGLE_HALF    = 12'd1800;
    localparam logic [11:0] ANGLE_QUARTER = 12'd900;
    localparam logic signed [21:0] OUT_MAX = 22'sd131071;
    localparam logic signed [21:0] OUT_MIN = -22'sd131072;

    typedef enum logic [2:0] {
        REG_SEMI_AXIS_A    = 3'd0,
        REG_SEMI_AXIS_B    = 3'd1,
        REG_CENTRE_X       = 3'd2,
        REG_CENTRE_Y       = 3'd3,
        REG_SCALE_TENTHS   = 3'd4,
        REG_ROTATION       = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic       neg;
        logic [9:0] ang;
    } fold_t;

    typedef struct packed {
        logic [7:0]  idx;
        logic        neg_x;
        logic        neg_y;
        logic [46:0] nx;
        logic [46:0] ny;
    } side_t;

    typedef struct packed {
        logic [7:0]  idx;
        logic        neg_x;
        logic        neg_y;
        logic        den_zero;
        logic [36:0] divisor;
        logic [19:0] qx;
        logic [19:0] qy;
    } div_t;

    function automatic logic [11:0] wrap_full(input logic [12:0] t);
        logic [12:0] w;
        w = (t >= ANGLE_FULL) ? t - ANGLE_FULL : t;
        return w[11:0];
    endfunction

    function automatic fold_t fold_quarter(input logic [11:0] t);
        fold_t       f;
        logic [11:0] h;
        logic [11:0] q;
        f.neg = (t >= ANGLE_HALF);
        h = f.neg ? t - ANGLE_HALF : t;
        q = (h > ANGLE_QUARTER) ? ANGLE_HALF - h : h;
        f.ang = q[9:0];
        return f;
    endfunction

    // Q0.15 sine magnitude of a first-quadrant angle in tenths of a degree.
    function automatic logic [14:0] sin_quarter(input logic [9:0] t);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] q;
        x = (64'(t) * PI_Q30 + 64'd900) / 64'd1800;
        x2 = (x * x) >> 30;
        term = x;
        sum = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + signed'(term);
        if (sum < 0) begin
            sum = 0;
        end
        q = (unsigned'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[14:0];
    endfunction

endpackage

// File: hw/rtl/ellipse_point_generator.sv
// Gives one outline point of a scaled, rotated ellipse for each sample index:
// the angle is index * 360 / POINTS degrees, the polar radius comes from the
// semi-axes and the scale, and the point is the centre plus that radius turned
// by the rotation register, rounded to whole pixels and saturated to 18 bits.
// The block takes one transfer per clock while the skid register is empty and
// gives one result per input, in order. The square root has 32 stages and the
// divider 20 stages; an output skid register lets one more input enter while a
// result waits. Registers are to be written only while no transfer is in flight;
// the block itself does not enforce this.
module ellipse_point_generator
    import epg_pkg::*;
#(
    parameter int POINTS = 180
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [17:0] point_x, [35:18] point_y, [43:36] point_index
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);

    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = 20;

    logic [11:0]        a_reg, b_reg, rot_reg;
    logic signed [13:0] cx_reg, cy_reg;
    logic [7:0]         scale_reg;
    logic [11:0]        rot_mod_reg;
    logic [23:0]        a2_reg, b2_reg, ab_reg;
    logic [31:0]        num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg     <= 12'd1;
            b_reg     <= 12'd1;
            cx_reg    <= '0;
            cy_reg    <= '0;
            scale_reg <= 8'd10;
            rot_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SEMI_AXIS_A:  a_reg     <= cfg_wdata[11:0];
                REG_SEMI_AXIS_B:  b_reg     <= cfg_wdata[11:0];
                REG_CENTRE_X:     cx_reg    <= signed'(cfg_wdata);
                REG_CENTRE_Y:     cy_reg    <= signed'(cfg_wdata);
                REG_SCALE_TENTHS: scale_reg <= cfg_wdata[7:0];
                REG_ROTATION:     rot_reg   <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rot_mod_reg <= wrap_full({1'b0, rot_reg});
        a2_reg      <= a_reg * a_reg;
        b2_reg      <= b_reg * b_reg;
        ab_reg      <= a_reg * b_reg;
        num_reg     <= 32'(scale_reg) * 32'(ab_reg);
    end

    logic [11:0] th_lut [0:255];
    logic [14:0] sm_lut [0:255];
    logic [14:0] cm_lut [0:255];
    logic [14:0] sin_rom [0:900];

    for (genvar gi = 0; gi < 256; gi++) begin : g_idx_lut
        localparam int TH = ((gi * 7200 + POINTS) / (2 * POINTS)) % 3600;
        assign th_lut[gi] = 12'(TH);
        assign sm_lut[gi] = sin_quarter(fold_quarter(12'(TH)).ang);
        assign cm_lut[gi] = sin_quarter(fold_quarter(wrap_full(13'(TH + 900))).ang);
    end

    for (genvar gr = 0; gr <= 900; gr++) begin : g_sin_rom
        assign sin_rom[gr] = sin_quarter(10'(gr));
    end

    logic en;
    logic skid_vld_reg;
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Front stages: angle, squares, folding, table read, sum.
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [7:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [11:0] th1_reg, tu2_reg;
    logic [14:0] sm1_reg, cm1_reg;
    logic [29:0] s2_reg, c2_reg;
    fold_t       fs3_reg, fc3_reg;
    logic [53:0] da3_reg, db3_reg;
    logic [14:0] rs4_reg, rc4_reg;
    logic        ns4_reg, nc4_reg;
    logic [54:0] d4_reg;
    logic [11:0] tu_sum;

    assign tu_sum = wrap_full(13'(th1_reg) + 13'(rot_mod_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx1_reg <= s_tdata;
            th1_reg  <= th_lut[s_tdata];
            sm1_reg  <= sm_lut[s_tdata];
            cm1_reg  <= cm_lut[s_tdata];

            idx2_reg <= idx1_reg;
            tu2_reg  <= tu_sum;
            s2_reg   <= sm1_reg * sm1_reg;
            c2_reg   <= cm1_reg * cm1_reg;

            idx3_reg <= idx2_reg;
            fs3_reg  <= fold_quarter(tu2_reg);
            fc3_reg  <= fold_quarter(wrap_full(13'(tu2_reg) + 13'(ANGLE_QUARTER)));
            da3_reg  <= a2_reg * s2_reg;
            db3_reg  <= b2_reg * c2_reg;

            idx4_reg <= idx3_reg;
            rs4_reg  <= sin_rom[fs3_reg.ang];
            rc4_reg  <= sin_rom[fc3_reg.ang];
            ns4_reg  <= fs3_reg.neg;
            nc4_reg  <= fc3_reg.neg;
            d4_reg   <= 55'(da3_reg) + 55'(db3_reg);
        end
    end

    // Square root, one result bit per stage.
    logic [63:0] sq_v_reg   [0:SQ_STAGES];
    logic [63:0] sq_r_reg   [0:SQ_STAGES];
    logic        sq_vld_reg [0:SQ_STAGES];
    side_t       sq_side_reg [0:SQ_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_v_reg[0]          <= {1'b0, d4_reg, 8'd0};
            sq_r_reg[0]          <= '0;
            sq_side_reg[0].idx   <= idx4_reg;
            sq_side_reg[0].neg_x <= nc4_reg;
            sq_side_reg[0].neg_y <= ns4_reg;
            sq_side_reg[0].nx    <= 47'(num_reg) * 47'(rc4_reg);
            sq_side_reg[0].ny    <= 47'(num_reg) * 47'(rs4_reg);
        end
    end

    for (genvar gs = 0; gs < SQ_STAGES; gs++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gs);
        logic [63:0] trial;
        logic        fit;
        assign trial = sq_r_reg[gs] + BIT;
        assign fit   = sq_v_reg[gs] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[gs+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[gs+1] <= sq_vld_reg[gs];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[gs+1] <= sq_side_reg[gs];
                if (fit) begin
                    sq_v_reg[gs+1] <= sq_v_reg[gs] - trial;
                    sq_r_reg[gs+1] <= (sq_r_reg[gs] >> 1) + BIT;
                end else begin
                    sq_v_reg[gs+1] <= sq_v_reg[gs];
                    sq_r_reg[gs+1] <= sq_r_reg[gs] >> 1;
                end
            end
        end
    end

    // Denominator and rounding setup.
    logic        den_vld_reg, prep_vld_reg;
    logic [35:0] den_reg;
    side_t       den_side_reg;
    logic [31:0] root;
    assign root = sq_r_reg[SQ_STAGES][31:0];

    logic [52:0] dv_remx_reg [0:DIV_STAGES];
    logic [52:0] dv_remy_reg [0:DIV_STAGES];
    logic        dv_vld_reg  [0:DIV_STAGES];
    div_t        dv_reg      [0:DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            den_vld_reg   <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            den_vld_reg   <= sq_vld_reg[SQ_STAGES];
            dv_vld_reg[0] <= den_vld_reg;
        end
    end

    assign prep_vld_reg = dv_vld_reg[0];

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg      <= {1'b0, root, 3'd0} + {3'd0, root, 1'b0};
            den_side_reg <= sq_side_reg[SQ_STAGES];

            dv_remx_reg[0]      <= {1'b0, den_side_reg.nx, 5'd0} + 53'(den_reg);
            dv_remy_reg[0]      <= {1'b0, den_side_reg.ny, 5'd0} + 53'(den_reg);
            dv_reg[0].idx       <= den_side_reg.idx;
            dv_reg[0].neg_x     <= den_side_reg.neg_x;
            dv_reg[0].neg_y     <= den_side_reg.neg_y;
            dv_reg[0].den_zero  <= (den_reg == '0);
            dv_reg[0].divisor   <= {den_reg, 1'b0};
            dv_reg[0].qx        <= '0;
            dv_reg[0].qy        <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    for (genvar gd = 0; gd < DIV_STAGES; gd++) begin : g_div
        localparam int SH = DIV_STAGES - 1 - gd;
        logic [55:0] trial;
        logic        gex, gey;
        div_t        stage_next;
        assign trial = 56'(dv_reg[gd].divisor) << SH;
        assign gex   = {3'd0, dv_remx_reg[gd]} >= trial;
        assign gey   = {3'd0, dv_remy_reg[gd]} >= trial;

        always_comb begin
            stage_next        = dv_reg[gd];
            stage_next.qx[SH] = gex;
            stage_next.qy[SH] = gey;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[gd+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[gd+1] <= dv_vld_reg[gd];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[gd+1] <= stage_next;
                dv_remx_reg[gd+1] <= gex ? dv_remx_reg[gd] - trial[52:0] : dv_remx_reg[gd];
                dv_remy_reg[gd+1] <= gey ? dv_remy_reg[gd] - trial[52:0] : dv_remy_reg[gd];
            end
        end
    end

    // Centre offset and saturation.
    div_t               fin;
    logic [19:0]        qx, qy;
    logic signed [21:0] ox, oy, sx, sy;
    logic [17:0]        px, py;
    logic [47:0]        pipe_data;
    logic               pipe_vld;

    always_comb begin
        fin = dv_reg[DIV_STAGES];
        qx  = fin.den_zero ? '0 : fin.qx;
        qy  = fin.den_zero ? '0 : fin.qy;
        ox  = fin.neg_x ? -signed'({2'd0, qx}) : signed'({2'd0, qx});
        oy  = fin.neg_y ? -signed'({2'd0, qy}) : signed'({2'd0, qy});
        sx  = 22'(cx_reg) + ox;
        sy  = 22'(cy_reg) + oy;
        if (sx > OUT_MAX) begin
            px = OUT_MAX[17:0];
        end else if (sx < OUT_MIN) begin
            px = OUT_MIN[17:0];
        end else begin
            px = sx[17:0];
        end
        if (sy > OUT_MAX) begin
            py = OUT_MAX[17:0];
        end else if (sy < OUT_MIN) begin
            py = OUT_MIN[17:0];
        end else begin
            py = sy[17:0];
        end
        pipe_data = {4'd0, fin.idx, py, px};
        pipe_vld  = dv_vld_reg[DIV_STAGES];
    end

    // Output register with skid.
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg, skid_data_reg;
    logic        take;

    assign take     = m_tvalid_reg && m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (take) begin
                m_tdata_reg  <= skid_data_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (pipe_vld) begin
            if (!m_tvalid_reg || take) begin
                m_tdata_reg  <= pipe_data;
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_data_reg <= pipe_data;
                skid_vld_reg  <= 1'b1;
            end
        end else if (take) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_tvalid_reg)
        else $error("skid register holds a result while the output is empty");

    a_skid_refills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && take) |=> (m_tvalid_reg && !skid_vld_reg))
        else $error("skid transfer to output lost a result");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && !m_tready) |=> (skid_vld_reg && $stable(skid_data_reg)))
        else $error("skid register changed while output stalled");

    a_prep_follows_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && den_vld_reg) |=> prep_vld_reg)
        else $error("divider stage lost an item");

endmodule
